### rtl/core/ial_pkg.sv
// ----------------------------------------------------------------------------
// ial_pkg
// Shared types and constants of the contiguous array list: command and
// status codes, store geometry and the command and result item structs.
// ----------------------------------------------------------------------------
package ial_pkg;

  localparam int unsigned DEPTH  = 256;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = ADDR_W + 1;

  localparam logic [3:0] CMD_READ      = 4'd0;
  localparam logic [3:0] CMD_WRITE     = 4'd1;
  localparam logic [3:0] CMD_INS_AT    = 4'd2;
  localparam logic [3:0] CMD_INS_FIRST = 4'd3;
  localparam logic [3:0] CMD_INS_LAST  = 4'd4;
  localparam logic [3:0] CMD_DEL_AT    = 4'd5;
  localparam logic [3:0] CMD_DEL_FIRST = 4'd6;
  localparam logic [3:0] CMD_DEL_LAST  = 4'd7;
  localparam logic [3:0] CMD_FIND_GT   = 4'd8;
  localparam logic [3:0] CMD_CLEAR     = 4'd9;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [3:0]         command;
    logic [7:0]         index;
    logic signed [31:0] value;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic               found;
    logic [7:0]         found_index;
    logic [8:0]         count;
  } res_item_t;

endpackage

### rtl/core/indexed_array_list_top.sv
// ----------------------------------------------------------------------------
// indexed_array_list_top
// Contiguous list of signed Q16.16 entries in a single-port-write store;
// shifts and searches walk the store one entry per cycle.
// ----------------------------------------------------------------------------
// Write, insert last/empty-first, delete last, clear and rejects reply straight from
//   idle; read passes through S_READ; insert at/first walk S_UP, then S_UPFIN;
//   delete at/first walk S_DN; find walks S_FIND until a hit or the end.
// A new command is taken only while busy is low, and every walk holds busy.
// Reset clears the count and sets capacity to DEPTH; the store is not swept.
// Results show for one cycle on res_valid_o; the receiver cannot stall.
module indexed_array_list_top import ial_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  cmd_item_t cmd_i,
  input  logic      cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  output logic      res_valid_o,
  output res_item_t res_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_UP    = 3'd2;
  localparam logic [2:0] S_UPFIN = 3'd3;
  localparam logic [2:0] S_DN    = 3'd4;
  localparam logic [2:0] S_FIND  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [8:0]         cap_q;
  logic [CNT_W-1:0]   eff_cap;
  logic               full;

  logic [ADDR_W-1:0]  pos_q, pos_d;
  logic signed [31:0] val_q, val_d;
  logic [CNT_W-1:0]   ptr_q, ptr_d;
  logic               pend_q, pend_d;
  logic [ADDR_W-1:0]  pend_addr_q, pend_addr_d;

  logic               res_valid_q, res_valid_d;
  res_item_t          res_q, res_d;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_q;
  logic [ADDR_W-1:0]  rd_addr;
  logic               we;
  logic [ADDR_W-1:0]  wr_addr;
  logic signed [31:0] wr_data;

  logic               accept;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Saturate capacity to 1..DEPTH
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (CNT_W'(cap_q) > CNT_W'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = CNT_W'(cap_q);
    end
  end
  assign full = (count_q >= eff_cap);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    val_d       = val_q;
    ptr_d       = ptr_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    rd_addr     = ptr_q[ADDR_W-1:0];
    we          = 1'b0;
    wr_addr     = pend_addr_q;
    wr_data     = rdata_q;

    unique case (state_q)
      S_IDLE: begin
        rd_addr = cmd_i.index;
        if (accept) begin
          res_valid_d       = 1'b1;
          res_d.status      = ST_OK;
          res_d.read_value  = '0;
          res_d.found       = 1'b0;
          res_d.found_index = '0;
          pos_d             = cmd_i.index;
          val_d             = cmd_i.value;
          unique case (cmd_i.command) inside
            CMD_READ: begin
              if (CNT_W'(cmd_i.index) < count_q) begin
                res_valid_d = 1'b0;
                state_d     = S_READ;
              end else begin
                res_d.status = ST_BAD_INDEX;
              end
            end
            CMD_WRITE: begin
              if (CNT_W'(cmd_i.index) < count_q) begin
                we      = 1'b1;
                wr_addr = cmd_i.index;
                wr_data = cmd_i.value;
              end else begin
                res_d.status = ST_BAD_INDEX;
              end
            end
            CMD_INS_AT: begin
              if (full) begin
                res_d.status = ST_FULL;
              end else if (CNT_W'(cmd_i.index) >= count_q) begin
                res_d.status = ST_BAD_INDEX;
              end else begin
                res_valid_d = 1'b0;
                ptr_d       = count_q;
                state_d     = S_UP;
              end
            end
            CMD_INS_FIRST: begin
              if (count_q == '0) begin
                we      = 1'b1;
                wr_addr = '0;
                wr_data = cmd_i.value;
                count_d = CNT_W'(1);
              end else if (full) begin
                res_d.status = ST_FULL;
              end else begin
                res_valid_d = 1'b0;
                pos_d       = '0;
                ptr_d       = count_q;
                state_d     = S_UP;
              end
            end
            CMD_INS_LAST: begin
              if (full) begin
                res_d.status = ST_FULL;
              end else begin
                we      = 1'b1;
                wr_addr = count_q[ADDR_W-1:0];
                wr_data = cmd_i.value;
                count_d = count_q + CNT_W'(1);
              end
            end
            CMD_DEL_AT, CMD_DEL_FIRST: begin
              if (cmd_i.command == CMD_DEL_FIRST) begin
                pos_d = '0;
              end
              if (CNT_W'(pos_d) < count_q) begin
                res_valid_d = 1'b0;
                ptr_d       = CNT_W'(pos_d) + CNT_W'(1);
                state_d     = S_DN;
              end else begin
                res_d.status = ST_BAD_INDEX;
              end
            end
            CMD_DEL_LAST: begin
              if (count_q == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                count_d = count_q - CNT_W'(1);
              end
            end
            CMD_FIND_GT: begin
              if (count_q == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                res_valid_d = 1'b0;
                ptr_d       = '0;
                state_d     = S_FIND;
              end
            end
            CMD_CLEAR: begin
              count_d = '0;
            end
            default: begin
              // unused codes: report ok, leave state alone
            end
          endcase
          res_d.count = count_d;
        end
      end

      S_READ: begin
        res_valid_d      = 1'b1;
        res_d.read_value = rdata_q;
        state_d          = S_IDLE;
      end

      // Walk down from the top: read entry ptr-1, write it one place up
      // on the next cycle.
      S_UP: begin
        rd_addr = ADDR_W'(ptr_q - CNT_W'(1));
        we      = pend_q;
        if (ptr_q != CNT_W'(pos_q)) begin
          pend_d      = 1'b1;
          pend_addr_d = ptr_q[ADDR_W-1:0];
          ptr_d       = ptr_q - CNT_W'(1);
        end else begin
          state_d = S_UPFIN;
        end
      end

      S_UPFIN: begin
        we          = 1'b1;
        wr_addr     = pos_q;
        wr_data     = val_q;
        count_d     = count_q + CNT_W'(1);
        res_valid_d = 1'b1;
        res_d.count = count_d;
        state_d     = S_IDLE;
      end

      // Walk up from the gap: read entry ptr, write it one place down.
      S_DN: begin
        we = pend_q;
        if (ptr_q < count_q) begin
          pend_d      = 1'b1;
          pend_addr_d = ADDR_W'(ptr_q - CNT_W'(1));
          ptr_d       = ptr_q + CNT_W'(1);
        end else begin
          count_d     = count_q - CNT_W'(1);
          res_valid_d = 1'b1;
          res_d.count = count_d;
          state_d     = S_IDLE;
        end
      end

      S_FIND: begin
        if (pend_q && (rdata_q > val_q)) begin
          res_valid_d       = 1'b1;
          res_d.found       = 1'b1;
          res_d.found_index = pend_addr_q;
          state_d           = S_IDLE;
        end else if (ptr_q < count_q) begin
          pend_d      = 1'b1;
          pend_addr_d = ptr_q[ADDR_W-1:0];
          ptr_d       = ptr_q + CNT_W'(1);
        end else begin
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cap_q       <= 9'(DEPTH);
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    val_q       <= val_d;
    ptr_q       <= ptr_d;
    pend_addr_q <= pend_addr_d;
    res_q       <= res_d;
  end

endmodule

### verif/ial_reply_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ial_reply_checker
// Watches the command, configuration and reply channels of the array list.
// Keeps its own copy of the list and capacity, works out the reply of every
// accepted command and compares it field by field with the replies in order.
// ----------------------------------------------------------------------------
module ial_reply_checker import ial_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  cmd_item_t   cmd_i,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        res_valid_i,
  input  res_item_t   res_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned list_len_o
);

  localparam int unsigned REPORT_MAX = 10;

  logic signed [31:0] list_entries [DEPTH];
  int unsigned        list_len;
  logic [8:0]         capacity_reg;
  res_item_t          due_replies [$];
  int unsigned        mismatches;

  // Apply one command to the list copy and return the reply it should get.
  function automatic res_item_t apply_list_command(cmd_item_t it);
    res_item_t   r;
    int unsigned lim;
    int unsigned pos;
    bit          full;
    r = '0;
    lim = capacity_reg;
    if (lim < 1) lim = 1;
    if (lim > DEPTH) lim = DEPTH;
    full = (list_len >= lim);
    case (it.command)
      CMD_READ: begin
        if (it.index < list_len) r.read_value = list_entries[it.index];
        else r.status = ST_BAD_INDEX;
      end
      CMD_WRITE: begin
        if (it.index < list_len) list_entries[it.index] = it.value;
        else r.status = ST_BAD_INDEX;
      end
      CMD_INS_AT: begin
        if (full) begin
          r.status = ST_FULL;
        end else if (it.index >= list_len) begin
          r.status = ST_BAD_INDEX;
        end else begin
          for (int i = list_len; i > it.index; i--) list_entries[i] = list_entries[i-1];
          list_entries[it.index] = it.value;
          list_len++;
        end
      end
      CMD_INS_FIRST: begin
        // an empty list takes the entry with no full check
        if (list_len == 0) begin
          list_entries[0] = it.value;
          list_len = 1;
        end else if (full) begin
          r.status = ST_FULL;
        end else begin
          for (int i = list_len; i > 0; i--) list_entries[i] = list_entries[i-1];
          list_entries[0] = it.value;
          list_len++;
        end
      end
      CMD_INS_LAST: begin
        if (full) begin
          r.status = ST_FULL;
        end else begin
          list_entries[list_len] = it.value;
          list_len++;
        end
      end
      CMD_DEL_AT, CMD_DEL_FIRST: begin
        pos = (it.command == CMD_DEL_FIRST) ? 0 : it.index;
        if (pos < list_len) begin
          for (int i = pos; i + 1 < list_len; i++) list_entries[i] = list_entries[i+1];
          list_len--;
        end else begin
          r.status = ST_BAD_INDEX;
        end
      end
      CMD_DEL_LAST: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else list_len--;
      end
      CMD_FIND_GT: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < list_len; i++) begin
            if ($signed(list_entries[i]) > $signed(it.value)) begin
              r.found = 1'b1;
              r.found_index = i[7:0];
              break;
            end
          end
        end
      end
      CMD_CLEAR: list_len = 0;
      default: ;
    endcase
    r.count = list_len[8:0];
    return r;
  endfunction

  function automatic void check_reply(res_item_t got);
    res_item_t want;
    if (due_replies.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: reply with no command waiting: st=%0d rd=%h fnd=%0d fidx=%0d cnt=%0d",
                 $realtime, got.status, got.read_value, got.found, got.found_index,
                 got.count);
      return;
    end
    want = due_replies.pop_front();
    if (got.status !== want.status || got.read_value !== want.read_value ||
        got.found !== want.found || got.found_index !== want.found_index ||
        got.count !== want.count) begin
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("%0t: reply mismatch, want st=%0d rd=%h fnd=%0d fidx=%0d cnt=%0d",
                 $realtime, want.status, want.read_value, want.found, want.found_index,
                 want.count);
        $display("%0t:                 got  st=%0d rd=%h fnd=%0d fidx=%0d cnt=%0d",
                 $realtime, got.status, got.read_value, got.found, got.found_index,
                 got.count);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      capacity_reg = 9'd256;
      due_replies.delete();
      mismatches = 0;
      errors_o <= 0;
      pending_o <= 0;
      list_len_o <= 0;
    end else begin
      // retire the reply of an earlier command before taking a new one
      if (res_valid_i) check_reply(res_i);
      if (cfg_we_i) capacity_reg = cfg_wdata_i;
      if (start_i && !busy_i) due_replies.push_back(apply_list_command(cmd_i));
      errors_o <= mismatches;
      pending_o <= due_replies.size();
      list_len_o <= list_len;
    end
  end

endmodule

### verif/indexed_array_list_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_array_list_top_tb
// Drives list commands into the array list: a directed opening over the
// empty, full and index edge cases, then random phases at several capacities
// with random gaps between items. A checker beside the block predicts and
// compares every reply; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module indexed_array_list_top_tb;
  import ial_pkg::*;

  localparam logic [3:0]  CMD_SPARE_LO = CMD_CLEAR + 4'd1;
  localparam logic [3:0]  CMD_SPARE_HI = 4'hF;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned SETTLE_CYCLES = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  cmd_item_t   cmd;
  logic        cfg_we;
  logic [8:0]  cfg_wdata;
  logic        res_valid;
  res_item_t   res;

  int unsigned fails;
  int unsigned replies_due;
  int unsigned list_len;
  int unsigned cycles;
  int unsigned burst_left;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  indexed_array_list_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ial_reply_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .res_valid_i (res_valid),
    .res_i       (res),
    .errors_o    (fails),
    .pending_o   (replies_due),
    .list_len_o  (list_len)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic cmd_item_t mk_item(logic [3:0] c, logic [7:0] ix, logic [31:0] v);
    cmd_item_t it;
    it.command = c;
    it.index = ix;
    it.value = v;
    return it;
  endfunction

  // Mostly back to back or short, now and then a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [3:0] pick_command(int unsigned grow_pct, int unsigned clear_pct);
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      k = $urandom_range(CMD_SPARE_LO, CMD_SPARE_HI);
      return k[3:0];
    end
    if (r < 2 + clear_pct) return CMD_CLEAR;
    r = $urandom_range(0, 99);
    if (r < 14) return CMD_READ;
    if (r < 28) return CMD_WRITE;
    if (r < 42) return CMD_FIND_GT;
    k = $urandom_range(0, 2);
    if ($urandom_range(0, 99) < grow_pct)
      return (k == 0) ? CMD_INS_AT : (k == 1) ? CMD_INS_FIRST : CMD_INS_LAST;
    return (k == 0) ? CMD_DEL_AT : (k == 1) ? CMD_DEL_FIRST : CMD_DEL_LAST;
  endfunction

  // Aim mostly inside the list, sometimes at its end or beyond.
  function automatic logic [7:0] pick_index(int unsigned len);
    int unsigned r;
    int unsigned p;
    r = $urandom_range(0, 99);
    if (len > 0 && r < 60) p = $urandom_range(0, len - 1);
    else if (r < 72) p = len;
    else if (r < 80) p = 255;
    else if (r < 85) p = 0;
    else p = $urandom_range(0, 255);
    return p[7:0];
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned r;
    int          s;
    r = $urandom_range(0, 99);
    if (r < 8) return 32'h7FFF_FFFF;
    if (r < 16) return 32'h8000_0000;
    if (r < 22) return 32'hFFFF_FFFF;
    if (r < 26) return 32'h0000_0000;
    if (r < 60) begin
      // small values around zero so searches hit and miss
      s = $urandom_range(0, 16);
      s = (s - 8) * 65536 + $urandom_range(0, 65535);
      return s;
    end
    return $urandom;
  endfunction

  task automatic send_item(input cmd_item_t it);
    int unsigned gap;
    start <= 1'b1;
    cmd <= it;
    do @(posedge clk_i); while (busy);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off until every reply is in and the block is idle.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (replies_due != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_capacity(input int unsigned c);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= c[8:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned cap, input int unsigned n,
                           input int unsigned grow_pct, input int unsigned clear_pct);
    cmd_item_t it;
    set_capacity(cap);
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 199) == 0) burst_left = 40;
      it.command = pick_command(grow_pct, clear_pct);
      it.index = pick_index(list_len);
      it.value = pick_value();
      send_item(it);
      if ($urandom_range(0, 99) == 0) drain();
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    start <= 1'b0;
    cmd <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    burst_left = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list edge cases at the reset capacity, then index edges on a short list
    send_item(mk_item(CMD_READ,      8'd0,   32'h0000_0000));
    send_item(mk_item(CMD_DEL_FIRST, 8'd0,   32'h0000_0000));
    send_item(mk_item(CMD_DEL_LAST,  8'd0,   32'h0000_0000));
    send_item(mk_item(CMD_FIND_GT,   8'd0,   32'h8000_0000));
    send_item(mk_item(CMD_INS_AT,    8'd0,   32'h1234_5678));
    send_item(mk_item(CMD_INS_FIRST, 8'd0,   32'h7FFF_FFFF));
    send_item(mk_item(CMD_INS_LAST,  8'd255, 32'h8000_0000));
    send_item(mk_item(CMD_INS_AT,    8'd0,   32'hFFFF_FFFF));
    send_item(mk_item(CMD_READ,      8'd2,   32'h0000_0000));
    send_item(mk_item(CMD_READ,      8'd3,   32'h0000_0000));
    send_item(mk_item(CMD_WRITE,     8'd1,   32'h0001_8000));
    send_item(mk_item(CMD_FIND_GT,   8'd0,   32'h8000_0000));
    send_item(mk_item(CMD_FIND_GT,   8'd0,   32'h7FFF_FFFF));
    send_item(mk_item(CMD_SPARE_HI,  8'd255, 32'hFFFF_FFFF));
    send_item(mk_item(CMD_DEL_AT,    8'd255, 32'h0000_0000));

    // zero capacity acts as one, already below the count
    set_capacity(0);
    send_item(mk_item(CMD_INS_LAST,  8'd0,   32'h0000_0001));
    send_item(mk_item(CMD_INS_FIRST, 8'd0,   32'h0000_0002));
    send_item(mk_item(CMD_INS_AT,    8'd255, 32'h0000_0003));
    send_item(mk_item(CMD_DEL_AT,    8'd1,   32'h0000_0000));
    send_item(mk_item(CMD_DEL_FIRST, 8'd0,   32'h0000_0000));
    send_item(mk_item(CMD_INS_LAST,  8'd0,   32'h0000_0004));
    send_item(mk_item(CMD_DEL_LAST,  8'd0,   32'h0000_0000));
    send_item(mk_item(CMD_INS_FIRST, 8'd0,   32'h5555_AAAA));

    // oversized capacity saturates to the store depth
    set_capacity(511);
    send_item(mk_item(CMD_WRITE,     8'd0,   32'hAAAA_5555));
    send_item(mk_item(CMD_CLEAR,     8'd0,   32'h0000_0000));

    run_phase(8,                       150, 55, 2);
    run_phase(1,                        60, 50, 2);
    run_phase(0,                        60, 50, 2);
    run_phase($urandom_range(2, 16),   170, 50, 2);
    run_phase(511,                     520, 100, 0);
    run_phase(4,                       120, 20, 0);
    run_phase($urandom_range(17, 255), 170, 45, 2);
    run_phase(256,                     200, 50, 3);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
